// ===== rtl/gmte_pkg.sv =====
`default_nettype none
package gmte_pkg;

	localparam int CHAR_W  = 8;
	localparam int TIME_W  = 27;
	localparam int CFG_W   = 24;
	localparam int QBITS   = 27;
	localparam int FRACW   = 30;
	localparam int FD_W    = 4;

	localparam logic [TIME_W-1:0] DAY_MS      = 27'd86400000;
	localparam logic [TIME_W-1:0] MOVE_CAP    = 27'd86399999;
	localparam logic [CFG_W-1:0]  FEED_RESET  = 24'd7500;
	localparam logic [15:0]       MS_PER_MIN  = 16'd60000;
	localparam logic [7:0]        G_ABS       = 8'd90;
	localparam logic [7:0]        G_REL       = 8'd91;

	typedef enum logic [2:0] {
		L_NONE, L_G, L_M, L_X, L_Y, L_Z, L_S, L_F
	} letter_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_FRAC_SETUP, ST_FRAC_DIV, ST_WORD, ST_SQ_PREP,
		ST_SQ_MUL, ST_SQ_DRAIN, ST_SQRT, ST_SCALE, ST_DIV_SETUP, ST_DIV, ST_RESULT
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       decode;
		logic       frac_setup;
		logic       div_step;
		logic       word_commit;
		logic       sq_prep;
		logic       sq_mul;
		logic       sqrt_step;
		logic       scale;
		logic       div_setup;
		logic       result;
		logic [1:0] axis;
		logic [1:0] part;
	} cmd_t;

	typedef struct packed {
		logic eol;
		logic skipped;
		logic word_end;
		logic need_frac;
		logic feed_bad;
		logic out_busy;
	} sts_t;

	function automatic logic [FRACW-1:0] pow10(input logic [FD_W-1:0] n);
		logic [FRACW-1:0] r;
		case (n)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			4'd9: r = 30'd1000000000;
			default: r = 30'd1;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/gmte_if.sv =====
`default_nettype none
interface gmte_in_if;
	logic                        valid;
	logic                        ready;
	logic [gmte_pkg::CHAR_W-1:0] char_code;
	logic                        end_of_line;
	logic                        new_program;
	modport source (output valid, char_code, end_of_line, new_program, input ready);
	modport sink (input valid, char_code, end_of_line, new_program, output ready);
endinterface

interface gmte_out_if;
	logic                        valid;
	logic                        ready;
	logic [gmte_pkg::TIME_W-1:0] total_ms;
	logic [gmte_pkg::TIME_W-1:0] move_ms;
	logic                        relative_now;
	logic                        feed_invalid;
	modport source (output valid, total_ms, move_ms, relative_now, feed_invalid, input ready);
	modport sink (input valid, total_ms, move_ms, relative_now, feed_invalid, output ready);
endinterface

interface gmte_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [gmte_pkg::CFG_W-1:0] initial_feed;
	modport source (output valid, initial_feed, input ready);
	modport sink (input valid, initial_feed, output ready);
endinterface
`default_nettype wire

// ===== rtl/gmte_ctrl.sv =====
`default_nettype none
module gmte_ctrl #(
	parameter int FRAC = 16,
	parameter int INTB = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire gmte_pkg::sts_t sts,
	output gmte_pkg::cmd_t      cmd
);
	localparam int RW      = INTB + FRAC + 2;
	localparam int MAXSTEP = (RW > gmte_pkg::QBITS) ? RW : gmte_pkg::QBITS;
	localparam int CNTW    = $clog2(MAXSTEP);

	gmte_pkg::state_t state_q, state_d;
	logic [CNTW-1:0]  cnt_q;
	logic [1:0]       axis_q, part_q;
	logic             last_mul;

	assign last_mul = (axis_q == 2'd2) && (part_q == 2'd2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gmte_pkg::ST_IDLE: begin
				if (in_valid) state_d = gmte_pkg::ST_DECODE;
			end
			gmte_pkg::ST_DECODE: begin
				if (sts.eol && sts.skipped) state_d = gmte_pkg::ST_RESULT;
				else if (sts.eol || sts.word_end)
					state_d = sts.need_frac ? gmte_pkg::ST_FRAC_SETUP : gmte_pkg::ST_WORD;
				else state_d = gmte_pkg::ST_IDLE;
			end
			gmte_pkg::ST_FRAC_SETUP: state_d = gmte_pkg::ST_FRAC_DIV;
			gmte_pkg::ST_FRAC_DIV: begin
				if (cnt_q == '0) state_d = gmte_pkg::ST_WORD;
			end
			gmte_pkg::ST_WORD: state_d = sts.eol ? gmte_pkg::ST_SQ_PREP : gmte_pkg::ST_IDLE;
			gmte_pkg::ST_SQ_PREP: state_d = gmte_pkg::ST_SQ_MUL;
			gmte_pkg::ST_SQ_MUL: begin
				if (last_mul) state_d = gmte_pkg::ST_SQ_DRAIN;
			end
			gmte_pkg::ST_SQ_DRAIN: state_d = sts.feed_bad ? gmte_pkg::ST_RESULT : gmte_pkg::ST_SQRT;
			gmte_pkg::ST_SQRT: begin
				if (cnt_q == '0) state_d = gmte_pkg::ST_SCALE;
			end
			gmte_pkg::ST_SCALE: state_d = gmte_pkg::ST_DIV_SETUP;
			gmte_pkg::ST_DIV_SETUP: state_d = gmte_pkg::ST_DIV;
			gmte_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = gmte_pkg::ST_RESULT;
			end
			gmte_pkg::ST_RESULT: begin
				if (!sts.out_busy) state_d = gmte_pkg::ST_IDLE;
			end
			default: state_d = gmte_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		cmd.part = part_q;
		in_ready = 1'b0;
		case (state_q)
			gmte_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			gmte_pkg::ST_DECODE:     cmd.decode      = 1'b1;
			gmte_pkg::ST_FRAC_SETUP: cmd.frac_setup  = 1'b1;
			gmte_pkg::ST_FRAC_DIV:   cmd.div_step    = 1'b1;
			gmte_pkg::ST_WORD:       cmd.word_commit = 1'b1;
			gmte_pkg::ST_SQ_PREP:    cmd.sq_prep     = 1'b1;
			gmte_pkg::ST_SQ_MUL:     cmd.sq_mul      = 1'b1;
			gmte_pkg::ST_SQRT:       cmd.sqrt_step   = 1'b1;
			gmte_pkg::ST_SCALE:      cmd.scale       = 1'b1;
			gmte_pkg::ST_DIV_SETUP:  cmd.div_setup   = 1'b1;
			gmte_pkg::ST_DIV:        cmd.div_step    = 1'b1;
			gmte_pkg::ST_RESULT:     cmd.result      = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmte_pkg::ST_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
			part_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				gmte_pkg::ST_FRAC_SETUP: cnt_q <= CNTW'(FRAC - 1);
				gmte_pkg::ST_SQ_DRAIN:   cnt_q <= CNTW'(RW - 1);
				gmte_pkg::ST_DIV_SETUP:  cnt_q <= CNTW'(gmte_pkg::QBITS - 1);
				gmte_pkg::ST_FRAC_DIV, gmte_pkg::ST_SQRT, gmte_pkg::ST_DIV: cnt_q <= cnt_q - 1'b1;
				gmte_pkg::ST_SQ_PREP: begin
					axis_q <= '0;
					part_q <= '0;
				end
				gmte_pkg::ST_SQ_MUL: begin
					if (part_q == 2'd2) begin
						part_q <= '0;
						axis_q <= axis_q + 1'b1;
					end else begin
						part_q <= part_q + 1'b1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gmte_dp.sv =====
`default_nettype none
module gmte_dp #(
	parameter int FRAC  = 16,
	parameter int INTB  = 24,
	parameter int MAXFD = 6
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [gmte_pkg::CHAR_W-1:0] in_char,
	input  wire logic                        in_eol,
	input  wire logic                        in_np,
	input  wire logic                        cfg_we,
	input  wire logic [gmte_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [gmte_pkg::TIME_W-1:0]      out_total,
	output logic [gmte_pkg::TIME_W-1:0]      out_move,
	output logic                             out_rel,
	output logic                             out_fbad,
	input  wire gmte_pkg::cmd_t              cmd,
	output gmte_pkg::sts_t                   sts
);
	localparam int W    = INTB + FRAC;
	localparam int MAGW = W + 1;
	localparam int H    = (MAGW + 1) / 2;
	localparam int SUMW = 2 * W + 4;
	localparam int RW   = W + 2;
	localparam int DIVW = W + 27;
	localparam int NIW  = INTB + 1;
	localparam int TW   = gmte_pkg::TIME_W;
	localparam int QB   = gmte_pkg::QBITS;
	localparam logic signed [W-1:0] MAX_RAW = {1'b0, {(W-1){1'b1}}};
	localparam logic [NIW+3:0]      IP_CAP  = (NIW+4)'(1) << INTB;

	function automatic logic signed [W-1:0] feed_of(input logic [gmte_pkg::CFG_W-1:0] v);
		logic [W+23:0] fw;
		fw = (W+24)'(v) << FRAC;
		return (fw > (W+24)'(MAX_RAW)) ? MAX_RAW : W'(fw);
	endfunction

	function automatic gmte_pkg::letter_t letter_of(input logic [7:0] c);
		gmte_pkg::letter_t l;
		case (c)
			"G": l = gmte_pkg::L_G;
			"M": l = gmte_pkg::L_M;
			"X": l = gmte_pkg::L_X;
			"Y": l = gmte_pkg::L_Y;
			"Z": l = gmte_pkg::L_Z;
			"S": l = gmte_pkg::L_S;
			"F": l = gmte_pkg::L_F;
			default: l = gmte_pkg::L_NONE;
		endcase
		return l;
	endfunction

	// item and parse state
	logic [7:0]                  char_q;
	logic                        eol_q;
	logic                        rel_q;
	logic signed [W-1:0]         last_q [3];
	logic signed [W-1:0]         pend_q [3];
	logic signed [W-1:0]         feed_q;
	logic [gmte_pkg::CFG_W-1:0]  init_feed_q;
	gmte_pkg::letter_t           letter_q, next_letter_q;
	logic [NIW-1:0]              nint_q;
	logic [gmte_pkg::FRACW-1:0]  nfrac_q;
	logic [gmte_pkg::FD_W-1:0]   nfd_q;
	logic                        neg_q, point_q, digits_q, bad_q;
	logic                        first_q, skip_q, cmt_q;
	logic [TW-1:0]               total_q;

	// arithmetic
	logic [MAGW-1:0]             mag_q [3];
	logic [2*H-1:0]              prod_s1;
	logic [1:0]                  part_s1;
	logic                        prod_vld_s1;
	logic [SUMW-1:0]             op_q, res_q, one_q;
	logic [DIVW-1:0]             rem_q, dsh_q;
	logic [QB-1:0]               quo_q;
	logic                        ovf_q, fbad_q;

	// decode
	logic [7:0]  cu;
	logic        numchar, bdchar, num_ok, word_end, need_frac;
	logic [3:0]  digit;
	logic [NIW+3:0] nint_x;
	assign cu       = (char_q >= "a" && char_q <= "z") ? char_q - 8'd32 : char_q;
	assign numchar  = (cu == "-") || (cu == ".") || (cu >= "0" && cu <= "9");
	assign bdchar   = (cu == "B") || (cu == "D") || (cu == "$");
	assign digit    = 4'(cu - "0");
	assign nint_x   = (NIW+4)'(nint_q) * (NIW+4)'(10) + (NIW+4)'(digit);
	assign num_ok   = digits_q && !bad_q;
	assign word_end = !eol_q && !skip_q && !cmt_q && !(first_q && bdchar) && (cu != ";")
		&& !numchar;
	assign need_frac = num_ok && (nfd_q != '0) && (letter_q == gmte_pkg::L_X ||
		letter_q == gmte_pkg::L_Y || letter_q == gmte_pkg::L_Z || letter_q == gmte_pkg::L_F);

	// word value
	logic [W:0]          raw;
	logic signed [W-1:0] mag_val, fixed;
	assign raw     = {nint_q, {FRAC{1'b0}}} + (W+1)'(need_frac ? quo_q[FRAC-1:0] : '0);
	assign mag_val = (raw > (W+1)'(MAX_RAW)) ? MAX_RAW : W'(raw);
	assign fixed   = !num_ok ? '0 : (neg_q ? -mag_val : mag_val);

	// squares and root
	logic signed [W:0] dlt [3];
	logic [H-1:0]      mop_a, mop_b, mlo, mhi;
	logic [SUMW-1:0]   prod_ext, root_t;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dlt[i] = rel_q ? (W+1)'(pend_q[i]) : (W+1)'(pend_q[i]) - (W+1)'(last_q[i]);
		end
		case (cmd.axis)
			2'd0: {mhi, mlo} = (2*H)'(mag_q[0]);
			2'd1: {mhi, mlo} = (2*H)'(mag_q[1]);
			default: {mhi, mlo} = (2*H)'(mag_q[2]);
		endcase
		case (cmd.part)
			2'd0: begin mop_a = mlo; mop_b = mlo; end
			2'd1: begin mop_a = mlo; mop_b = mhi; end
			default: begin mop_a = mhi; mop_b = mhi; end
		endcase
		case (part_s1)
			2'd0: prod_ext = SUMW'(prod_s1);
			2'd1: prod_ext = SUMW'(prod_s1) << (H + 1);
			default: prod_ext = SUMW'(prod_s1) << (2 * H);
		endcase
	end
	assign root_t = res_q + one_q;

	// relative sums, divisor, result
	logic signed [W:0]   rsum [3];
	logic [DIVW-1:0]     fpos;
	logic [TW-1:0]       move;
	logic [TW:0]         tsum;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = (W+1)'(last_q[i]) + (W+1)'(pend_q[i]);
		end
	end
	assign fpos = DIVW'(feed_q[W-2:0]);
	assign move = (skip_q || fbad_q) ? '0 : (ovf_q ? gmte_pkg::MOVE_CAP :
		((quo_q > gmte_pkg::MOVE_CAP) ? gmte_pkg::MOVE_CAP : quo_q));
	assign tsum = (TW+1)'(total_q) + (TW+1)'(move);

	assign sts.eol       = eol_q;
	assign sts.skipped   = skip_q;
	assign sts.word_end  = word_end;
	assign sts.need_frac = need_frac;
	assign sts.feed_bad  = fbad_q;
	assign sts.out_busy  = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0; eol_q <= 1'b0; rel_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				last_q[i] <= '0;
				pend_q[i] <= '0;
			end
			init_feed_q   <= gmte_pkg::FEED_RESET;
			feed_q        <= feed_of(gmte_pkg::FEED_RESET);
			letter_q      <= gmte_pkg::L_NONE;
			next_letter_q <= gmte_pkg::L_NONE;
			nint_q <= '0; nfrac_q <= '0; nfd_q <= '0;
			neg_q <= 1'b0; point_q <= 1'b0; digits_q <= 1'b0; bad_q <= 1'b0;
			first_q <= 1'b1; skip_q <= 1'b0; cmt_q <= 1'b0;
			total_q <= '0; prod_vld_s1 <= 1'b0; ovf_q <= 1'b0; fbad_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.sq_mul;
			if (cmd.result) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				init_feed_q <= cfg_data;
				if (!(cmd.accept && in_np)) feed_q <= feed_of(cfg_data);
			end
			if (cmd.accept) begin
				char_q <= in_char;
				eol_q  <= in_eol;
				if (in_np) begin
					rel_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						last_q[i] <= '0;
						pend_q[i] <= '0;
					end
					feed_q   <= feed_of(cfg_we ? cfg_data : init_feed_q);
					total_q  <= '0;
					letter_q <= gmte_pkg::L_NONE;
					nint_q <= '0; nfrac_q <= '0; nfd_q <= '0;
					neg_q <= 1'b0; point_q <= 1'b0; digits_q <= 1'b0; bad_q <= 1'b0;
					first_q <= 1'b1; skip_q <= 1'b0; cmt_q <= 1'b0;
				end
			end
			if (cmd.decode) begin
				if (eol_q) begin
					next_letter_q <= gmte_pkg::L_NONE;
				end else if (skip_q || cmt_q) begin
					first_q <= 1'b0;
				end else if (first_q && bdchar) begin
					first_q <= 1'b0;
					skip_q  <= 1'b1;
				end else begin
					first_q <= 1'b0;
					if (cu == ";") begin
						cmt_q <= 1'b1;
					end else if (numchar) begin
						if (letter_q != gmte_pkg::L_NONE) begin
							if (cu == "-") begin
								if (neg_q || point_q || digits_q) bad_q <= 1'b1;
								else neg_q <= 1'b1;
							end else if (cu == ".") begin
								if (point_q) bad_q <= 1'b1;
								else point_q <= 1'b1;
							end else begin
								digits_q <= 1'b1;
								if (!point_q) begin
									nint_q <= (nint_x > IP_CAP) ? IP_CAP[NIW-1:0]
										: nint_x[NIW-1:0];
								end else if (nfd_q < gmte_pkg::FD_W'(MAXFD)) begin
									nfrac_q <= nfrac_q * gmte_pkg::FRACW'(10)
										+ gmte_pkg::FRACW'(digit);
									nfd_q   <= nfd_q + 1'b1;
								end
							end
						end
					end else begin
						next_letter_q <= letter_of(cu);
					end
				end
			end
			if (cmd.frac_setup) begin
				rem_q <= DIVW'(nfrac_q) << FRAC;
				dsh_q <= DIVW'(gmte_pkg::pow10(nfd_q)) << (FRAC - 1);
				quo_q <= '0;
			end
			if (cmd.div_step) begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QB-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QB-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			if (cmd.word_commit) begin
				case (letter_q)
					gmte_pkg::L_G: begin
						if (num_ok && !point_q && !neg_q && (nint_q == NIW'(gmte_pkg::G_ABS)
							|| nint_q == NIW'(gmte_pkg::G_REL))) begin
							rel_q <= (nint_q == NIW'(gmte_pkg::G_REL));
							for (int i = 0; i < 3; i++) begin
								pend_q[i] <= (nint_q == NIW'(gmte_pkg::G_REL)) ? '0 : last_q[i];
							end
						end
					end
					gmte_pkg::L_X: pend_q[0] <= fixed;
					gmte_pkg::L_Y: pend_q[1] <= fixed;
					gmte_pkg::L_Z: pend_q[2] <= fixed;
					gmte_pkg::L_F: feed_q <= fixed;
					default: feed_q <= feed_q;
				endcase
				letter_q <= next_letter_q;
				nint_q <= '0; nfrac_q <= '0; nfd_q <= '0;
				neg_q <= 1'b0; point_q <= 1'b0; digits_q <= 1'b0; bad_q <= 1'b0;
			end
			if (cmd.sq_prep) begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= dlt[i][W] ? MAGW'(-dlt[i]) : MAGW'(dlt[i]);
					if (rel_q) begin
						if (rsum[i] > (W+1)'(MAX_RAW)) last_q[i] <= MAX_RAW;
						else if (rsum[i] < -(W+1)'(MAX_RAW)) last_q[i] <= -MAX_RAW;
						else last_q[i] <= W'(rsum[i]);
					end else begin
						last_q[i] <= pend_q[i];
					end
				end
				fbad_q <= (feed_q <= 0);
				op_q   <= '0;
				res_q  <= '0;
				one_q  <= SUMW'(1) << (SUMW - 2);
			end
			if (cmd.sq_mul) begin
				prod_s1 <= (2*H)'(mop_a) * (2*H)'(mop_b);
				part_s1 <= cmd.part;
			end
			if (prod_vld_s1) op_q <= op_q + prod_ext;
			if (cmd.sqrt_step) begin
				if (op_q >= root_t) begin
					op_q  <= op_q - root_t;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
			end
			if (cmd.scale) rem_q <= DIVW'(res_q[RW-1:0]) * DIVW'(gmte_pkg::MS_PER_MIN);
			if (cmd.div_setup) begin
				ovf_q <= rem_q >= (fpos << QB);
				dsh_q <= fpos << (QB - 1);
				quo_q <= '0;
			end
			if (cmd.result) begin
				out_total <= (tsum >= (TW+1)'(gmte_pkg::DAY_MS))
					? TW'(tsum - (TW+1)'(gmte_pkg::DAY_MS)) : TW'(tsum);
				total_q   <= (tsum >= (TW+1)'(gmte_pkg::DAY_MS))
					? TW'(tsum - (TW+1)'(gmte_pkg::DAY_MS)) : TW'(tsum);
				out_move  <= move;
				out_rel   <= rel_q;
				out_fbad  <= !skip_q && fbad_q;
				first_q <= 1'b1; skip_q <= 1'b0; cmt_q <= 1'b0;
				letter_q <= gmte_pkg::L_NONE;
				nint_q <= '0; nfrac_q <= '0; nfd_q <= '0;
				neg_q <= 1'b0; point_q <= 1'b0; digits_q <= 1'b0; bad_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					pend_q[i] <= rel_q ? '0 : last_q[i];
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gcode_move_time_estimator.sv =====
// g-code move time estimator
// in_ch takes one request per character (char_code), or a line end
// (end_of_line, no character); new_program clears positions, mode, feed and
// total before that request is handled
// out_ch gives one request per line end: running total, this line's time,
// relative mode and a bad-feed flag
// cfg_ch writes initial_feed at any handshake; ready is always high and the
// write also reloads the current feed
// a character passes a latch and a decode state; a word end adds a commit
// state, after a fraction setup and divide when it ends an X/Y/Z/F value
// with fraction digits; a line end takes 9 multiply steps,
// (COORD_INT_BITS+COORD_FRAC_BITS+2) square root steps and 27 divide steps;
// a skipped line end goes from decode straight to the result state, a bad feed
// skips the root and divide; one item is in work at a time
// the result sits in an output register; characters keep flowing while it
// waits, only the next line end holds in the result state until it drains
// reset: absolute mode, positions and total zero, feed = 7500 mm/min
`default_nettype none
module gcode_move_time_estimator #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int COORD_INT_BITS  = 24,
	parameter int MAX_FRAC_DIGITS = 6
) (
	input wire logic   clk,
	input wire logic   arst_n,
	gmte_in_if.sink    in_ch,
	gmte_out_if.source out_ch,
	gmte_cfg_if.sink   cfg_ch
);
	gmte_pkg::cmd_t cmd;
	gmte_pkg::sts_t sts;

	// configuration is always taken
	assign cfg_ch.ready = 1'b1;

	// sequencer
	gmte_ctrl #(
		.FRAC (COORD_FRAC_BITS),
		.INTB (COORD_INT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// parser, position state, multiplier, root and divider
	gmte_dp #(
		.FRAC  (COORD_FRAC_BITS),
		.INTB  (COORD_INT_BITS),
		.MAXFD (MAX_FRAC_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (in_ch.char_code),
		.in_eol    (in_ch.end_of_line),
		.in_np     (in_ch.new_program),
		.cfg_we    (cfg_ch.valid),
		.cfg_data  (cfg_ch.initial_feed),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_total (out_ch.total_ms),
		.out_move  (out_ch.move_ms),
		.out_rel   (out_ch.relative_now),
		.out_fbad  (out_ch.feed_invalid),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
`default_nettype wire

// ===== test/tb_gcode_move_time_estimator.sv =====
`default_nettype none
module tb_gcode_move_time_estimator;

	localparam int FRAC_BITS  = 16;
	localparam int INT_BITS   = 24;
	localparam int FRAC_DIGITS = 6;
	localparam longint COORD_MAX = (longint'(1) << (INT_BITS + FRAC_BITS - 1)) - 1;
	localparam longint INT_CAP   = longint'(1) << INT_BITS;
	localparam int LIMIT = 3000000;
	localparam int EXP_DEPTH = 1024;

	// per-line timing result
	typedef struct packed {
		logic [gmte_pkg::TIME_W-1:0] total_ms;
		logic [gmte_pkg::TIME_W-1:0] move_ms;
		logic                        relative_now;
		logic                        feed_invalid;
	} line_time_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gmte_in_if  in_ch();
	gmte_out_if out_ch();
	gmte_cfg_if cfg_ch();

	gcode_move_time_estimator dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// estimator state mirrored in the testbench
	logic [gmte_pkg::CFG_W-1:0]  cur_initial_feed;
	bit                          rel_mode;
	longint                      axis_pos[3];
	longint                      axis_next[3];
	longint                      cur_feed;
	gmte_pkg::letter_t           cur_letter;
	longint unsigned             n_int, n_frac;
	int                          n_fd;
	bit                          n_neg, n_point, n_digits, n_bad;
	bit                          at_first, skipping, in_comment;
	logic [gmte_pkg::TIME_W-1:0] running_total;

	// expected results, written at the tail and read at the head
	line_time_t exp_buf[EXP_DEPTH];
	int  exp_wr = 0;
	int  exp_rd = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  items_sent = 0;
	bit  no_idle = 1'b0;
	int  hold_off = 0;

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX) return COORD_MAX;
		if (v < -COORD_MAX) return -COORD_MAX;
		return v;
	endfunction

	function automatic void reload_axes();
		for (int i = 0; i < 3; i++) axis_next[i] = rel_mode ? 0 : axis_pos[i];
	endfunction

	function automatic void reload_feed();
		longint f;
		f = longint'(cur_initial_feed) << FRAC_BITS;
		cur_feed = f > COORD_MAX ? COORD_MAX : f;
	endfunction

	function automatic void clear_num();
		n_int = 0; n_frac = 0; n_fd = 0;
		n_neg = 0; n_point = 0; n_digits = 0; n_bad = 0;
	endfunction

	function automatic void start_line();
		at_first = 1; skipping = 0; in_comment = 0;
		cur_letter = gmte_pkg::L_NONE;
		clear_num();
		reload_axes();
	endfunction

	function automatic void clear_program();
		rel_mode = 0;
		for (int i = 0; i < 3; i++) axis_pos[i] = 0;
		reload_feed();
		running_total = '0;
		start_line();
	endfunction

	function automatic longint num_value();
		longint unsigned p10, raw;
		longint v;
		if (!n_digits || n_bad) return 0;
		p10 = 1;
		for (int i = 0; i < n_fd; i++) p10 = p10 * 10;
		raw = (n_int << FRAC_BITS) + ((n_frac << FRAC_BITS) / p10);
		v = raw > longint'(COORD_MAX) ? COORD_MAX : longint'(raw);
		return n_neg ? -v : v;
	endfunction

	function automatic void take_digit_char(byte unsigned c);
		if (c == "-") begin
			if (n_neg || n_point || n_digits) n_bad = 1; else n_neg = 1;
		end else if (c == ".") begin
			if (n_point) n_bad = 1; else n_point = 1;
		end else begin
			n_digits = 1;
			if (!n_point) begin
				n_int = n_int * 10 + (c - "0");
				if (n_int > INT_CAP) n_int = INT_CAP;
			end else if (n_fd < FRAC_DIGITS) begin
				n_frac = n_frac * 10 + (c - "0");
				n_fd++;
			end
		end
	endfunction

	function automatic void close_word(byte unsigned c);
		if (cur_letter == gmte_pkg::L_G) begin
			if (n_digits && !n_bad && !n_point && !n_neg && (n_int == 90 || n_int == 91)) begin
				rel_mode = (n_int == 91);
				reload_axes();
			end
		end else if (cur_letter inside {gmte_pkg::L_X, gmte_pkg::L_Y, gmte_pkg::L_Z}) begin
			axis_next[int'(cur_letter) - int'(gmte_pkg::L_X)] = num_value();
		end else if (cur_letter == gmte_pkg::L_F) begin
			cur_feed = num_value();
		end
		case (c)
			"G": cur_letter = gmte_pkg::L_G;
			"M": cur_letter = gmte_pkg::L_M;
			"X": cur_letter = gmte_pkg::L_X;
			"Y": cur_letter = gmte_pkg::L_Y;
			"Z": cur_letter = gmte_pkg::L_Z;
			"S": cur_letter = gmte_pkg::L_S;
			"F": cur_letter = gmte_pkg::L_F;
			default: cur_letter = gmte_pkg::L_NONE;
		endcase
		clear_num();
	endfunction

	// straight-line time of the finished line, also commits the positions
	function automatic longint unsigned line_move_ms(output bit bad_feed);
		logic [127:0] sum, root, q, n;
		longint d;
		longint unsigned m;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d = rel_mode ? axis_next[i] : axis_next[i] - axis_pos[i];
			m = d < 0 ? longint'(-d) : d;
			sum += 128'(m) * 128'(m);
			axis_pos[i] = rel_mode ? clamp_coord(axis_pos[i] + axis_next[i]) : axis_next[i];
		end
		bad_feed = cur_feed <= 0;
		if (bad_feed) return 0;
		root = 0;
		for (int b = 57; b >= 0; b--)
			if ((root | (128'(1) << b)) * (root | (128'(1) << b)) <= sum)
				root = root | (128'(1) << b);
		n = root * 128'(60000);
		q = 0;
		for (int b = 26; b >= 0; b--)
			if ((q | (128'(1) << b)) * 128'(cur_feed) <= n) q = q | (128'(1) << b);
		return q > gmte_pkg::MOVE_CAP ? gmte_pkg::MOVE_CAP : q;
	endfunction

	function automatic void predict_item(byte unsigned ch, bit eol, bit newp);
		line_time_t r;
		longint unsigned mv;
		bit bad;
		byte unsigned c;
		if (newp) clear_program();
		if (eol) begin
			mv = 0; bad = 0;
			if (!skipping) begin
				close_word(" ");
				mv = line_move_ms(bad);
				running_total = gmte_pkg::TIME_W'((longint'(running_total) + mv)
					% longint'(gmte_pkg::DAY_MS));
			end
			r.total_ms = running_total;
			r.move_ms = gmte_pkg::TIME_W'(mv);
			r.relative_now = rel_mode;
			r.feed_invalid = bad;
			exp_buf[exp_wr % EXP_DEPTH] = r;
			exp_wr++;
			start_line();
			return;
		end
		c = ch;
		if (c >= "a" && c <= "z") c = c - 32;
		if (skipping || in_comment) begin
			at_first = 0;
			return;
		end
		if (at_first) begin
			at_first = 0;
			if (c == "B" || c == "D" || c == "$") begin
				skipping = 1;
				return;
			end
		end
		if (c == ";") begin
			in_comment = 1;
			return;
		end
		if (c == "-" || c == "." || (c >= "0" && c <= "9")) begin
			if (cur_letter != gmte_pkg::L_NONE) take_digit_char(c);
		end else begin
			close_word(c);
		end
	endfunction

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stall bursts, long hold-off on request
	initial begin
		int burst;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ch.ready <= 1'b0;
				hold_off--;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11);
				out_ch.ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// result checker, compares each accepted request with the oldest expectation
	always @(posedge clk) begin
		line_time_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected line result total=%0d move=%0d",
					out_ch.total_ms, out_ch.move_ms);
			end else begin
				want = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (out_ch.total_ms !== want.total_ms || out_ch.move_ms !== want.move_ms ||
						out_ch.relative_now !== want.relative_now ||
						out_ch.feed_invalid !== want.feed_invalid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp t=%0d m=%0d r=%0b f=%0b got t=%0d m=%0d r=%0b f=%0b",
							want.total_ms, want.move_ms, want.relative_now, want.feed_invalid,
							out_ch.total_ms, out_ch.move_ms, out_ch.relative_now,
							out_ch.feed_invalid);
				end
			end
		end
	end

	// one character or line-end request, with a random gap before it;
	// valid stays up afterwards so the next request can follow directly
	task automatic send_item(byte unsigned ch, bit eol, bit newp = 1'b0);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_code <= ch;
		in_ch.end_of_line <= eol;
		in_ch.new_program <= newp;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_item(ch, eol, newp);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_line(string s, bit newp = 1'b0);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, newp && i == 0);
		send_item(8'($urandom_range(0, 255)), 1'b1, newp && s.len() == 0);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (exp_wr != exp_rd) @(negedge clk);
	endtask

	task automatic write_initial_feed(logic [gmte_pkg::CFG_W-1:0] f);
		cfg_ch.valid <= 1'b1;
		cfg_ch.initial_feed <= f;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cur_initial_feed = f;
		reload_feed();
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic string rand_number();
		string s;
		int k;
		s = "";
		k = $urandom_range(0, 9);
		if (k == 0) return "-";
		if (k == 1) return "1.2.3";
		if (k == 2) return "5-";
		if ($urandom_range(0, 2) == 0) s = "-";
		s = {s, $sformatf("%0d", $urandom_range(0, k == 3 ? 99999999 : 400))};
		if ($urandom_range(0, 1)) s = {s, ".", $sformatf("%0d", $urandom_range(0, 99999999))};
		return s;
	endfunction

	// mostly well-formed move lines, some noise characters
	task automatic send_random_line();
		string s;
		int words;
		byte unsigned noise;
		s = "";
		case ($urandom_range(0, 19))
			0: s = "$";
			1: s = "b";
			2: s = "D";
			default: ;
		endcase
		words = $urandom_range(0, 5);
		for (int w = 0; w < words; w++) begin
			case ($urandom_range(0, 9))
				0: s = {s, $urandom_range(0, 1) ? "G90" : "g91"};
				1: s = {s, "G", $sformatf("%0d", $urandom_range(0, 3))};
				2: s = {s, "F", $urandom_range(0, 7) == 0 ? "0"
					: $sformatf("%0d", $urandom_range(1, 9000))};
				3: s = {s, "M", rand_number()};
				4: s = {s, "S", rand_number()};
				5: s = {s, "x", rand_number()};
				6: s = {s, "Y", rand_number()};
				7: s = {s, "Z", rand_number()};
				8: begin
					noise = $urandom_range(0, 255);
					s = {s, string'(noise)};
				end
				default: s = {s, "X", rand_number()};
			endcase
			if ($urandom_range(0, 1)) s = {s, " "};
		end
		if ($urandom_range(0, 9) == 0) s = {s, ";X99 G91"};
		send_line(s, $urandom_range(0, 29) == 0);
	endtask

	task automatic test_directed();
		send_line("G1 X10 Y20 F600");
		send_line("x-10.5 y.25 z3.1234567");
		send_line("G91 X1 Y1");
		send_line("G90 X99999999 Y-99999999");
		send_line("G91 X99999999.999");
		send_line("G91 X99999999");
		send_line("g90 X0 Y0 Z0 F0");
		send_line("X5 F-3");
		send_line("F.5 X1-2 Y--1 Z1..2 X");
		send_line("B X100");
		send_line("$ X100");
		send_line("X200 ; X900 F1");
		send_line("X1 \377\200Y2 S99 M3 G91.0 G-91");
		send_line("", 1'b1);
		send_line("F16777215 X0.000001 Y0.00001526");
		send_line("F1 X16000000");
		send_line("D1");
	endtask

	task automatic test_feed_settings();
		wait_drained();
		write_initial_feed(24'd1);
		send_line("X3 Y4", 1'b1);
		send_line("X-16777215 Y16777215 Z16777215");
		wait_drained();
		write_initial_feed(24'hFFFFFF);
		send_line("X100 Y100", 1'b1);
		wait_drained();
		write_initial_feed(24'(($urandom_range(1, 30000))));
		send_line("G91 X7 Z-7", 1'b1);
		wait_drained();
		write_initial_feed(gmte_pkg::FEED_RESET);
	endtask

	task automatic test_random_lines();
		while (items_sent < 480) send_random_line();
	endtask

	// receiver holds off while lines keep coming, then sender waits for drain
	task automatic test_back_pressure();
		hold_off = 3000;
		for (int i = 0; i < 6; i++) send_line("X1 Y2 G91");
		wait_drained();
		send_line("G90 X0");
	endtask

	task automatic test_no_idle_tail();
		no_idle = 1'b1;
		do send_random_line(); while (items_sent < 600);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.char_code = '0;
		in_ch.end_of_line = 1'b0;
		in_ch.new_program = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.initial_feed = '0;
		cur_initial_feed = gmte_pkg::FEED_RESET;
		clear_program();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_feed_settings();
		test_random_lines();
		test_back_pressure();
		test_no_idle_tail();
		wait_drained();
		if (mismatches == 0 && exp_wr == exp_rd) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
